FILE: rtl/ulapd_pkg.sv
package ulapd_pkg;

  typedef enum logic [1:0] {
    OP_PORT_WR  = 2'd0,
    OP_PORT_RD  = 2'd1,
    OP_KEY_ROW  = 2'd2,
    OP_JOYSTICK = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    VMODE_NORMAL = 2'd0,
    VMODE_COLOR  = 2'd1,
    VMODE_HIRES  = 2'd2
  } vmode_e;

  // port decode
  localparam logic [7:0]  PortModeLow  = 8'hFF;
  localparam logic [15:0] PortPalData  = 16'hBF3F;
  localparam logic [15:0] PortPalCtrl  = 16'hFF3B;

  // mode register low bits
  localparam logic [2:0]  ModeSelColor = 3'd2;
  localparam logic [2:0]  ModeSelHires = 3'd6;

  // floating bus window, inclusive
  localparam logic [16:0] FloatStart   = 17'd14347;
  localparam logic [16:0] FloatEnd     = 17'd57245;

  localparam logic [7:0]  UlaOutReset  = 8'd190;
  localparam logic [7:0]  ReadIdle     = 8'hFF;

  typedef struct packed {
    opcode_e     opcode;
    logic [15:0] port;
    logic [7:0]  data;
    logic [2:0]  row;
    logic [16:0] tick;
  } in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        float_request;
    logic [15:0] float_offset;
    logic        palette_write;
    logic [5:0]  palette_index;
    logic [7:0]  palette_value;
    logic        border_write;
    logic [2:0]  border_color;
    logic [1:0]  video_mode;
    logic        alt_screen;
    logic [2:0]  hires_ink_color;
    logic        palette_enabled;
  } out_t;

  typedef struct packed {
    logic       en;
    logic [2:0] row;
    logic [7:0] data;
  } kbd_wr_t;

endpackage

FILE: rtl/ulapd_kbd.sv
module ulapd_kbd (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ulapd_pkg::kbd_wr_t wr_i,
  input  logic [7:0]        high_i,
  output logic [7:0]        keys_o
);
  import ulapd_pkg::*;

  logic [7:0] rows_q [8];
  logic [7:0] first;
  logic [7:0] ghost;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 8; r++) begin
        rows_q[r] <= 8'h00;
      end
    end else if (wr_i.en) begin
      rows_q[wr_i.row] <= wr_i.data;
    end
  end

  // selected rows, then one pass of ghost-key spread
  always_comb begin
    first = 8'h00;
    for (int r = 0; r < 8; r++) begin
      if (!high_i[r]) first = first | rows_q[r];
    end
    ghost = first;
    for (int r = 0; r < 8; r++) begin
      if ((first & rows_q[r]) != 8'h00) ghost = ghost | rows_q[r];
    end
  end

  assign keys_o = ~ghost;

endmodule

FILE: rtl/ulapd_ctrl.sv
module ulapd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  ulapd_pkg::in_t     req_i,
  input  logic [7:0]         keys_i,
  output ulapd_pkg::kbd_wr_t kbd_wr_o,
  output ulapd_pkg::out_t    rsp_o
);
  import ulapd_pkg::*;

  logic [7:0] ula_out_q, ula_out_d;
  logic [7:0] mode_q, mode_d;
  logic [2:0] ink_q, ink_d;
  logic       armed_q, armed_d;
  logic [5:0] pal_ptr_q, pal_ptr_d;
  logic       pal_on_q, pal_on_d;
  logic [7:0] stick_q, stick_d;
  logic [7:0] keyval;
  logic [16:0] float_diff;
  logic       in_window;

  assign float_diff = req_i.tick - FloatStart;
  assign in_window  = (req_i.tick >= FloatStart) && (req_i.tick <= FloatEnd);

  always_comb begin
    keyval    = keys_i;
    keyval[6] = ula_out_q[4];
  end

  assign kbd_wr_o.en   = fire_i && (req_i.opcode == OP_KEY_ROW);
  assign kbd_wr_o.row  = req_i.row;
  assign kbd_wr_o.data = req_i.data;

  always_comb begin
    ula_out_d = ula_out_q;
    mode_d    = mode_q;
    ink_d     = ink_q;
    armed_d   = armed_q;
    pal_ptr_d = pal_ptr_q;
    pal_on_d  = pal_on_q;
    stick_d   = stick_q;

    rsp_o               = '0;
    rsp_o.read_data     = ReadIdle;

    case (req_i.opcode)
      OP_PORT_WR: begin
        if (req_i.port[7:0] == PortModeLow) begin
          mode_d = req_i.data;
          if (req_i.data[2:0] == ModeSelHires) ink_d = req_i.data[5:3];
        end else if (req_i.port == PortPalData && pal_on_q) begin
          if (!armed_q && req_i.data[7:6] == 2'b00) begin
            pal_ptr_d = req_i.data[5:0];
            armed_d   = 1'b1;
          end else begin
            rsp_o.palette_write = 1'b1;
            rsp_o.palette_index = pal_ptr_q;
            rsp_o.palette_value = req_i.data;
            armed_d             = 1'b0;
          end
        end else if (req_i.port == PortPalCtrl) begin
          pal_on_d = req_i.data[0];
          armed_d  = 1'b0;
        end else if (!req_i.port[0]) begin
          ula_out_d          = req_i.data;
          rsp_o.border_write = 1'b1;
        end
      end
      OP_PORT_RD: begin
        if (req_i.port[7:0] == PortModeLow) begin
          rsp_o.read_data = mode_q;
        end else if (!req_i.port[5]) begin
          rsp_o.read_data = stick_q;
        end else if (!req_i.port[0]) begin
          rsp_o.read_data = keyval;
        end else if (in_window) begin
          rsp_o.float_request = 1'b1;
          rsp_o.float_offset  = float_diff[15:0];
        end
      end
      OP_KEY_ROW: begin
        // key matrix lives in the keyboard block
      end
      OP_JOYSTICK: begin
        stick_d = req_i.data;
      end
      default: begin
      end
    endcase

    case (mode_d[2:0])
      ModeSelColor: rsp_o.video_mode = VMODE_COLOR;
      ModeSelHires: rsp_o.video_mode = VMODE_HIRES;
      default:      rsp_o.video_mode = VMODE_NORMAL;
    endcase
    rsp_o.border_color    = ula_out_d[2:0];
    rsp_o.alt_screen      = mode_d[0];
    rsp_o.hires_ink_color = ink_d;
    rsp_o.palette_enabled = pal_on_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ula_out_q <= UlaOutReset;
      mode_q    <= 8'h00;
      ink_q     <= 3'd0;
      armed_q   <= 1'b0;
      pal_ptr_q <= 6'd0;
      pal_on_q  <= 1'b0;
      stick_q   <= 8'h00;
    end else if (fire_i) begin
      ula_out_q <= ula_out_d;
      mode_q    <= mode_d;
      ink_q     <= ink_d;
      armed_q   <= armed_d;
      pal_ptr_q <= pal_ptr_d;
      pal_on_q  <= pal_on_d;
      stick_q   <= stick_d;
    end
  end

endmodule

FILE: rtl/ula_io_port_decoder_core.sv
// request path: input register, then result register, from request accept to result valid
// throughput: one request per cycle while the consumer takes results; the decode, key matrix
// and state update all sit in a single combinational pass between the two registers
// reset: async active low; border/ear latch to 190, all other state and the key matrix to zero
module ula_io_port_decoder_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ulapd_pkg::in_t  in_req_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output ulapd_pkg::out_t out_rsp_o,
  output logic            out_valid_o,
  input  logic            out_ready_i
);
  import ulapd_pkg::*;

  // input stage
  logic    s1_valid_q;
  in_t     s1_req_q;
  // result stage
  logic    out_valid_q;
  out_t    out_rsp_q;

  logic    advance;   // result register can take a new value
  logic    fire;      // stage 1 request is decoded and commits state
  out_t    rsp;
  kbd_wr_t kbd_wr;
  logic [7:0] keys;

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = s1_valid_q && advance;
  // stage 1 frees up whenever its request moves on, so requests stream back to back
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_req_q <= in_req_i;
    end
  end

  // key matrix and ghost-key read, addressed by the port high byte
  ulapd_kbd u_kbd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (kbd_wr),
    .high_i (s1_req_q.port[15:8]),
    .keys_o (keys)
  );

  // port decode, mode/palette/border state and result build
  ulapd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .req_i    (s1_req_q),
    .keys_i   (keys),
    .kbd_wr_o (kbd_wr),
    .rsp_o    (rsp)
  );

  // result register doubles as the skid stage toward the consumer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef SYNTHESIS
  // stall only comes from a held result
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a held result");

  a_float_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.float_request) |-> (out_rsp_o.read_data == ReadIdle))
    else $error("floating bus request with read data");

  a_pal_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.palette_write && out_rsp_o.border_write))
    else $error("palette and border written by one request");

  a_pal_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.palette_write) |-> out_rsp_o.palette_enabled)
    else $error("palette write while palette disabled");
`endif

endmodule

FILE: tb/ula_io_port_decoder_core_tb.sv
`timescale 1ns / 1ps

module ula_io_port_decoder_core_tb;
  import ulapd_pkg::*;

  // run limits
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned SettleCycles = 10;   // long enough to drain the input and result registers
  localparam int unsigned RxHoldCycles = 80;   // long receiver hold-off
  localparam int unsigned PhaseItems  = 470;

  // scoreboard: mirrors the decoder state and queues one response per request
  class port_decode_scoreboard;
    logic [7:0] ula_out;
    logic [7:0] mode_reg;
    logic [2:0] ink_reg;
    logic       pal_armed;
    logic [5:0] pal_ptr;
    logic       pal_on;
    logic [7:0] key_rows [8];
    logic [7:0] stick;

    out_t        expected_rsp_q [$];
    int unsigned mismatch_count;
    int unsigned checked_count;
    int unsigned kbd_reads;
    int unsigned float_reads;
    int unsigned pal_writes;

    function new();
      ula_out   = UlaOutReset;
      mode_reg  = '0;
      ink_reg   = '0;
      pal_armed = 1'b0;
      pal_ptr   = '0;
      pal_on    = 1'b0;
      foreach (key_rows[i]) key_rows[i] = '0;
      stick          = '0;
      mismatch_count = 0;
      checked_count  = 0;
      kbd_reads      = 0;
      float_reads    = 0;
      pal_writes     = 0;
    endfunction

    // selected rows ORed, one ghost-key pass, inverted, bit 6 from ear
    function logic [7:0] key_matrix(logic [7:0] high);
      logic [7:0] acc;
      logic [7:0] seed;
      acc = '0;
      for (int r = 0; r < 8; r++) if (!high[r]) acc |= key_rows[r];
      seed = acc;
      for (int r = 0; r < 8; r++) if ((seed & key_rows[r]) != 8'h00) acc |= key_rows[r];
      acc    = ~acc;
      acc[6] = ula_out[4];
      return acc;
    endfunction

    function out_t decode_access(in_t req);
      out_t rsp;
      rsp           = '0;
      rsp.read_data = ReadIdle;
      case (req.opcode)
        OP_PORT_WR: begin
          if (req.port[7:0] == PortModeLow) begin
            mode_reg = req.data;
            if (req.data[2:0] == ModeSelHires) ink_reg = req.data[5:3];
          end else if (req.port == PortPalData && pal_on) begin
            if (!pal_armed && req.data[7:6] == 2'b00) begin
              pal_ptr   = req.data[5:0];
              pal_armed = 1'b1;
            end else begin
              rsp.palette_write = 1'b1;
              rsp.palette_index = pal_ptr;
              rsp.palette_value = req.data;
              pal_armed         = 1'b0;
              pal_writes++;
            end
          end else if (req.port == PortPalCtrl) begin
            pal_on    = req.data[0];
            pal_armed = 1'b0;
          end else if (!req.port[0]) begin
            ula_out          = req.data;
            rsp.border_write = 1'b1;
          end
        end
        OP_PORT_RD: begin
          if (req.port[7:0] == PortModeLow) begin
            rsp.read_data = mode_reg;
          end else if (!req.port[5]) begin
            rsp.read_data = stick;
          end else if (!req.port[0]) begin
            rsp.read_data = key_matrix(req.port[15:8]);
            kbd_reads++;
          end else if (req.tick >= FloatStart && req.tick <= FloatEnd) begin
            rsp.float_request = 1'b1;
            rsp.float_offset  = 16'(req.tick - FloatStart);
            float_reads++;
          end
        end
        OP_KEY_ROW: key_rows[req.row] = req.data;
        default:    stick = req.data;
      endcase
      case (mode_reg[2:0])
        ModeSelColor: rsp.video_mode = VMODE_COLOR;
        ModeSelHires: rsp.video_mode = VMODE_HIRES;
        default:      rsp.video_mode = VMODE_NORMAL;
      endcase
      rsp.border_color    = ula_out[2:0];
      rsp.alt_screen      = mode_reg[0];
      rsp.hires_ink_color = ink_reg;
      rsp.palette_enabled = pal_on;
      return rsp;
    endfunction

    function void note_request(in_t req);
      expected_rsp_q.push_back(decode_access(req));
    endfunction

    function void compare_field(string field, logic [15:0] want_v, logic [15:0] got_v);
      if (got_v !== want_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
        mismatch_count++;
      end
    endfunction

    function void check_response(out_t got);
      out_t want;
      if (expected_rsp_q.size() == 0) begin
        $error("response 0x%0h with no request outstanding", got);
        mismatch_count++;
        return;
      end
      want = expected_rsp_q.pop_front();
      checked_count++;
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("float_request", want.float_request, got.float_request);
      compare_field("float_offset", want.float_offset, got.float_offset);
      compare_field("palette_write", want.palette_write, got.palette_write);
      compare_field("palette_index", want.palette_index, got.palette_index);
      compare_field("palette_value", want.palette_value, got.palette_value);
      compare_field("border_write", want.border_write, got.border_write);
      compare_field("border_color", want.border_color, got.border_color);
      compare_field("video_mode", want.video_mode, got.video_mode);
      compare_field("alt_screen", want.alt_screen, got.alt_screen);
      compare_field("hires_ink_color", want.hires_ink_color, got.hires_ink_color);
      compare_field("palette_enabled", want.palette_enabled, got.palette_enabled);
    endfunction

    function int unsigned outstanding();
      return expected_rsp_q.size();
    endfunction
  endclass

  // dut signals, all inputs driven to known values from time zero
  logic clk_i;
  logic rst_ni      = 1'b0;
  in_t  in_req_i    = '0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  out_t out_rsp_o;
  logic out_valid_o;
  logic out_ready_i = 1'b0;

  port_decode_scoreboard sb = new();

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned rx_hold_seq = 0;   // bumped to ask the receiver for a long hold-off
  int unsigned sent_count  = 0;
  int unsigned cycle_count = 0;

  ula_io_port_decoder_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_req_i   (in_req_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_rsp_o  (out_rsp_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // response side: random back-pressure, plus a counted hold-off on request
  initial begin : rx_drive
    int unsigned seen_seq;
    int unsigned hold_left;
    seen_seq  = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_seq != seen_seq) begin
        seen_seq  = rx_hold_seq;
        hold_left = RxHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // every accepted response is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_response(out_rsp_o);
  end

  function automatic in_t make_req(opcode_e op, logic [15:0] port, logic [7:0] data,
                                   logic [2:0] row, logic [16:0] tick);
    in_t r;
    r.opcode = op;
    r.port   = port;
    r.data   = data;
    r.row    = row;
    r.tick   = tick;
    return r;
  endfunction

  // few bits set so ghost-key expansion actually triggers
  function automatic logic [7:0] sparse_byte();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'(1 << $urandom_range(7));
      2:       return 8'((1 << $urandom_range(7)) | (1 << $urandom_range(7)));
      default: return 8'($urandom);
    endcase
  endfunction

  // high byte of a keyboard read, zero bits select rows
  function automatic logic [7:0] row_select();
    case ($urandom_range(4))
      0:       return ~8'(1 << $urandom_range(7));
      1:       return ~8'((1 << $urandom_range(7)) | (1 << $urandom_range(7)));
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // window edges get extra weight, full 17-bit range now and then
  function automatic logic [16:0] pick_tick();
    case ($urandom_range(9))
      0:       return FloatStart - 17'd1;
      1:       return FloatStart;
      2:       return FloatEnd;
      3:       return FloatEnd + 17'd1;
      4:       return 17'($urandom_range(131071));
      default: return 17'($urandom_range(69887));
    endcase
  endfunction

  function automatic in_t random_request();
    logic [15:0] port;
    logic [7:0]  data;
    port = 16'($urandom);
    data = 8'($urandom);
    case ($urandom_range(9))
      0, 1, 2: begin
        case ($urandom_range(5))
          0:    port[7:0] = PortModeLow;
          1:    port = PortPalData;
          2:    port = PortPalCtrl;
          3, 4: port[0] = 1'b0;
          default: ;
        endcase
        if (port == PortPalData && $urandom_range(1)) data[7:6] = 2'b00;
        return make_req(OP_PORT_WR, port, data, 3'($urandom), pick_tick());
      end
      3, 4, 5, 6: begin
        case ($urandom_range(7))
          0:       port[7:0] = PortModeLow;
          1:       port[5] = 1'b0;
          2, 3, 4: port = {row_select(), (port[7:0] | 8'h20) & 8'hFE};
          5, 6: begin
            port[7:0] = port[7:0] | 8'h21;
            if (port[7:0] == PortModeLow) port[7:0] = 8'hFD;
          end
          default: ;
        endcase
        return make_req(OP_PORT_RD, port, data, 3'($urandom), pick_tick());
      end
      7, 8:    return make_req(OP_KEY_ROW, port, sparse_byte(), 3'($urandom), pick_tick());
      default: return make_req(OP_JOYSTICK, port, data, 3'($urandom), pick_tick());
    endcase
  endfunction

  // offer one request, with random idle cycles ahead of it
  task automatic send_request(in_t req);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_req_i   <= req;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    sb.note_request(req);
    sent_count++;
  endtask

  // well-formed palette write: enable, index, then colour byte
  task automatic send_palette_entry();
    send_request(make_req(OP_PORT_WR, PortPalCtrl, 8'($urandom) | 8'h01, 3'($urandom),
                          pick_tick()));
    send_request(make_req(OP_PORT_WR, PortPalData, {2'b00, 6'($urandom)}, 3'($urandom),
                          pick_tick()));
    send_request(make_req(OP_PORT_WR, PortPalData, 8'($urandom), 3'($urandom), pick_tick()));
  endtask

  task automatic run_random(int unsigned count);
    int unsigned done;
    done = 0;
    while (done < count) begin
      if ($urandom_range(9) == 0) begin
        send_palette_entry();
        done += 3;
      end else begin
        send_request(random_request());
        done++;
      end
    end
  endtask

  // sender pauses until every response is back, then lets the pipe settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // phase 1: sender idles lightly, receiver heavily
    tx_idle_pct = 34;
    rx_idle_pct = 82;

    // keyboard with nothing pressed, then a ghost pair on rows 0 and 3
    send_request(make_req(OP_PORT_RD, 16'h00FE, 8'h00, 3'd0, 17'd0));
    send_request(make_req(OP_KEY_ROW, 16'h0000, 8'h01, 3'd0, 17'd0));
    send_request(make_req(OP_KEY_ROW, 16'h0000, 8'h03, 3'd3, 17'd0));
    send_request(make_req(OP_KEY_ROW, 16'h0000, 8'h80, 3'd7, 17'd0));
    send_request(make_req(OP_PORT_RD, 16'hFEFE, 8'h00, 3'd0, 17'd0));
    send_request(make_req(OP_PORT_RD, 16'hFFFE, 8'h00, 3'd0, 17'd0));
    // joystick read through a port with bit 5 clear
    send_request(make_req(OP_JOYSTICK, 16'h0000, 8'hA5, 3'd0, 17'd0));
    send_request(make_req(OP_PORT_RD, 16'h001F, 8'h00, 3'd0, 17'd0));
    // mode register: hires with ink 7, alt screen, 8x1 colour
    send_request(make_req(OP_PORT_WR, 16'h00FF, 8'h3E, 3'd0, 17'd0));
    send_request(make_req(OP_PORT_RD, 16'hABFF, 8'h00, 3'd0, 17'd0));
    send_request(make_req(OP_PORT_WR, 16'hFFFF, 8'h03, 3'd0, 17'd0));
    send_request(make_req(OP_PORT_WR, 16'h12FF, 8'h02, 3'd0, 17'd0));
    // palette data port ignored while the palette is off
    send_request(make_req(OP_PORT_WR, PortPalData, 8'h10, 3'd0, 17'd0));
    // index then data, data without an index, arm then disarm via control
    send_request(make_req(OP_PORT_WR, PortPalCtrl, 8'h01, 3'd0, 17'd0));
    send_request(make_req(OP_PORT_WR, PortPalData, 8'h3F, 3'd0, 17'd0));
    send_request(make_req(OP_PORT_WR, PortPalData, 8'hFF, 3'd0, 17'd0));
    send_request(make_req(OP_PORT_WR, PortPalData, 8'hC0, 3'd0, 17'd0));
    send_request(make_req(OP_PORT_WR, PortPalData, 8'h00, 3'd0, 17'd0));
    send_request(make_req(OP_PORT_WR, PortPalCtrl, 8'h00, 3'd0, 17'd0));
    // border 7 with ear low shows up in keyboard bit 6
    send_request(make_req(OP_PORT_WR, 16'h0000, 8'hEF, 3'd0, 17'd0));
    send_request(make_req(OP_PORT_RD, 16'h00FE, 8'h00, 3'd0, 17'd0));
    // odd unmatched port write does nothing
    send_request(make_req(OP_PORT_WR, 16'h1235, 8'h55, 3'd0, 17'd0));
    // floating bus at and around the window edges
    send_request(make_req(OP_PORT_RD, 16'h00FD, 8'h00, 3'd0, FloatStart - 17'd1));
    send_request(make_req(OP_PORT_RD, 16'h00FD, 8'h00, 3'd0, FloatStart));
    send_request(make_req(OP_PORT_RD, 16'h00FD, 8'h00, 3'd0, FloatEnd));
    send_request(make_req(OP_PORT_RD, 16'h00FD, 8'h00, 3'd0, FloatEnd + 17'd1));

    run_random(PhaseItems);
    wait_drained();

    // phase 2: roles swapped
    tx_idle_pct = 82;
    rx_idle_pct = 34;
    run_random(PhaseItems);
    wait_drained();

    // phase 3: no idling; first a long receiver hold-off under full input load
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_seq++;
    run_random(40);
    wait_drained();
    run_random(PhaseItems - 40);
    wait_drained();

    $display("tb: %0d requests, %0d responses checked, %0d mismatches", sent_count,
             sb.checked_count, sb.mismatch_count);
    $display("tb: %0d keyboard reads, %0d floating-bus requests, %0d palette writes",
             sb.kbd_reads, sb.float_reads, sb.pal_writes);
    if (sb.mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/ulapd_pkg.sv
rtl/ulapd_kbd.sv
rtl/ulapd_ctrl.sv
rtl/ula_io_port_decoder_core.sv
tb/ula_io_port_decoder_core_tb.sv
